@@ sv/chip8_instruction_executor_core_defines.svh @@
// Assertion macros for the CHIP-8 executor core.
// Included by the top level; no other dependencies.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define C8_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define C8_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("%m failed");
`else
`define C8_ASSERT_IMPL(label, clk, rstn, prop)
`define C8_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

@@ sv/c8exec_pkg.sv @@
// Shared types and constants for the CHIP-8 executor core.
// No dependencies.
package c8exec_pkg;
    typedef enum logic [1:0] {
        OP_EXEC = 2'd0, OP_LOAD = 2'd1, OP_ROW = 2'd2, OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_UNKNOWN = 2'd1, ST_UNIMPL = 2'd2, ST_STACK = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE, FSM_EXEC, FSM_CLEAR, FSM_DRAW, FSM_STORE, FSM_LOAD, FSM_ROW, FSM_DONE
    } fsm_t;

    // machine geometry
    localparam int SCREEN_ROWS = 32;
    localparam int SCREEN_COLS = 64;
    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;

    localparam logic [7:0] KK_CLS  = 8'hE0;
    localparam logic [7:0] KK_RET  = 8'hEE;
    localparam logic [7:0] KK_SKP  = 8'h9E;
    localparam logic [7:0] KK_SKNP = 8'hA1;
    localparam logic [7:0] KK_GDT  = 8'h07;
    localparam logic [7:0] KK_SDT  = 8'h15;
    localparam logic [7:0] KK_SST  = 8'h18;
    localparam logic [7:0] KK_ADDI = 8'h1E;
    localparam logic [7:0] KK_STOR = 8'h55;
    localparam logic [7:0] KK_LDR  = 8'h65;
    localparam logic [7:0] KK_KEY  = 8'h0A;
    localparam logic [7:0] KK_FONT = 8'h29;
    localparam logic [7:0] KK_BCD  = 8'h33;
    localparam logic [11:0] PC_MASK = 12'h0FFF;
    localparam logic [11:0] PC_RESET = 12'h200;

    // controller -> datapath commands
    typedef struct packed {
        logic exec;        // single-cycle instruction step
        logic clr_step;    // step CLS through one row
        logic draw_rd;     // issue memory/frame reads for a sprite line
        logic draw_wr;     // write a sprite line back
        logic store_step;  // Fx55 one byte
        logic load_rd;     // Fx65 issue read
        logic load_wr;     // Fx65 write register
        logic mem_load;    // opcode 1
        logic row_rd;      // opcode 2 issue read
        logic row_cap;     // opcode 2 capture
        logic first;       // first step of an instruction
    } c8_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [3:0] nib;   // instruction high nibble
        logic [7:0] kk;
        logic [3:0] x;
        logic [3:0] n;
        logic       last;  // counter at last step
    } c8_stat_t;
endpackage

@@ sv/c8exec_ctrl.sv @@
// Controller state machine for the CHIP-8 executor core.
// Depends on c8exec_pkg.
module c8exec_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [1:0]           in_opcode,
    input  logic                 out_free,
    input  c8exec_pkg::c8_stat_t stat,
    output c8exec_pkg::c8_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    c8exec_pkg::fsm_t state_reg, state_next;
    logic ph_reg, ph_next;  // draw/load sub-phase

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= c8exec_pkg::FSM_IDLE;
            ph_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            c8exec_pkg::FSM_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    unique case (c8exec_pkg::opcode_t'(in_opcode))
                        c8exec_pkg::OP_EXEC: state_next = c8exec_pkg::FSM_EXEC;
                        c8exec_pkg::OP_LOAD: begin
                            cmd.mem_load = 1'b1;
                            state_next = c8exec_pkg::FSM_DONE;
                        end
                        c8exec_pkg::OP_ROW: begin
                            cmd.row_rd = 1'b1;
                            state_next = c8exec_pkg::FSM_ROW;
                        end
                        default: state_next = c8exec_pkg::FSM_DONE;
                    endcase
                end
            end
            c8exec_pkg::FSM_EXEC: begin
                cmd.exec  = 1'b1;
                cmd.first = 1'b1;
                ph_next   = 1'b0;
                state_next = c8exec_pkg::FSM_DONE;
                if (stat.nib == 4'h0 && stat.x == 4'h0 && stat.kk == c8exec_pkg::KK_CLS)
                    state_next = c8exec_pkg::FSM_CLEAR;
                else if (stat.nib == 4'hD && stat.n != 4'h0)
                    state_next = c8exec_pkg::FSM_DRAW;
                else if (stat.nib == 4'hF && stat.kk == c8exec_pkg::KK_STOR)
                    state_next = c8exec_pkg::FSM_STORE;
                else if (stat.nib == 4'hF && stat.kk == c8exec_pkg::KK_LDR)
                    state_next = c8exec_pkg::FSM_LOAD;
            end
            c8exec_pkg::FSM_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.last) state_next = c8exec_pkg::FSM_DONE;
            end
            c8exec_pkg::FSM_DRAW: begin
                if (!ph_reg) begin
                    cmd.draw_rd = 1'b1;
                    ph_next = 1'b1;
                end else begin
                    cmd.draw_wr = 1'b1;
                    ph_next = 1'b0;
                    if (stat.last) state_next = c8exec_pkg::FSM_DONE;
                end
            end
            c8exec_pkg::FSM_STORE: begin
                cmd.store_step = 1'b1;
                if (stat.last) state_next = c8exec_pkg::FSM_DONE;
            end
            c8exec_pkg::FSM_LOAD: begin
                if (!ph_reg) begin
                    cmd.load_rd = 1'b1;
                    ph_next = 1'b1;
                end else begin
                    cmd.load_wr = 1'b1;
                    ph_next = 1'b0;
                    if (stat.last) state_next = c8exec_pkg::FSM_DONE;
                end
            end
            c8exec_pkg::FSM_ROW: begin
                cmd.row_cap = 1'b1;
                state_next = c8exec_pkg::FSM_DONE;
            end
            c8exec_pkg::FSM_DONE: begin
                // wait for the output register to free up
                if (out_free) begin
                    done = 1'b1;
                    state_next = c8exec_pkg::FSM_IDLE;
                end
            end
            default: state_next = c8exec_pkg::FSM_IDLE;
        endcase
    end
endmodule

@@ sv/c8exec_dp.sv @@
// Datapath for the CHIP-8 executor core: registers, stack, memory, frame store.
// Depends on c8exec_pkg.
module c8exec_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [15:0]          in_instruction,
    input  logic [7:0]           in_random_byte,
    input  logic [11:0]          in_load_address,
    input  logic [7:0]           in_load_data,
    input  logic [4:0]           in_row_index,
    input  c8exec_pkg::c8_cmd_t  cmd,
    output c8exec_pkg::c8_stat_t stat,
    output logic [11:0]          pc_out,
    output logic [15:0]          index_out,
    output logic [7:0]           flag_out,
    output logic [1:0]           status_out,
    output logic [63:0]          row_out,
    output logic [7:0]           delay_out,
    output logic [7:0]           sound_out
);
    localparam int SCREEN_ROWS = c8exec_pkg::SCREEN_ROWS;
    localparam int SCREEN_COLS = c8exec_pkg::SCREEN_COLS;
    localparam int MEM_BYTES   = c8exec_pkg::MEM_BYTES;
    localparam int STACK_DEPTH = c8exec_pkg::STACK_DEPTH;
    localparam int AW = $clog2(MEM_BYTES);
    localparam int RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int NW = (RW > 4) ? RW : 4;

    logic [15:0] ins_reg;
    logic [7:0]  rnd_reg;
    logic [4:0]  row_idx_reg;
    logic [7:0]  v_reg [16];
    logic [15:0] index_reg;
    logic [11:0] pc_reg;
    logic [DW-1:0] depth_reg;
    logic [11:0] stack_mem [STACK_DEPTH];
    logic [7:0]  delay_reg, sound_reg;
    logic [1:0]  status_reg;
    logic [63:0] row_reg;
    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  mem_q;
    logic [63:0] fs_mem [SCREEN_ROWS];
    logic [SCREEN_ROWS-1:0] fs_valid_reg;  // row written since last clear
    logic [63:0] fs_q;
    logic        fs_qv;
    logic [NW-1:0] cnt_reg;
    logic [RW-1:0] draw_row_reg;
    logic [7:0]  dx_reg, dy_reg;  // sprite origin, held before VF is cleared

    logic [3:0] x, y, nib, n;
    logic [7:0] kk, vx, vy;
    logic [11:0] nnn, pc2, pc4;

    assign nib = ins_reg[15:12];
    assign x   = ins_reg[11:8];
    assign y   = ins_reg[7:4];
    assign n   = ins_reg[3:0];
    assign kk  = ins_reg[7:0];
    assign nnn = ins_reg[11:0];
    assign vx  = v_reg[x];
    assign vy  = v_reg[y];
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;

    always_comb begin
        stat.nib = nib;
        stat.kk  = kk;
        stat.x   = x;
        stat.n   = n;
        if (cmd.clr_step)
            stat.last = (cnt_reg[RW-1:0] == RW'(SCREEN_ROWS - 1));
        else if (cmd.draw_wr)
            stat.last = (cnt_reg[3:0] == n - 4'd1);
        else
            stat.last = (cnt_reg[3:0] == x);
    end

    // memory address for the current step: I + counter
    logic [AW-1:0] step_addr;
    assign step_addr = AW'(index_reg + 16'(cnt_reg[3:0]));

    // sprite line placement
    logic [RW-1:0] line_row;
    assign line_row = RW'((32'(dy_reg) + 32'(cnt_reg[3:0])) % SCREEN_ROWS);

    logic [63:0] spr_mask;
    always_comb begin
        spr_mask = '0;
        for (int c = 0; c < 8; c++) begin
            if (mem_q[7-c])
                spr_mask[63 - ((32'(dx_reg) + c) % SCREEN_COLS)] = 1'b1;
        end
    end

    logic [63:0] fs_cur;
    assign fs_cur = fs_qv ? fs_q : 64'd0;

    // memory: one write port and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.mem_load)
            mem[AW'(in_load_address)] <= in_load_data;
        else if (cmd.store_step)
            mem[step_addr] <= v_reg[cnt_reg[3:0]];
        mem_q <= mem[step_addr];
    end

    // frame store
    logic [RW-1:0] fs_raddr;
    assign fs_raddr = cmd.row_rd ? RW'(in_row_index) : line_row;
    always_ff @(posedge aclk) begin
        if (cmd.draw_wr)
            fs_mem[draw_row_reg] <= fs_cur ^ spr_mask;
        fs_q  <= fs_mem[fs_raddr];
        fs_qv <= fs_valid_reg[fs_raddr];
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ins_reg     <= in_instruction;
            rnd_reg     <= in_random_byte;
            row_idx_reg <= in_row_index;
        end
        if (cmd.exec) begin
            dx_reg <= vx;
            dy_reg <= vy;
        end
        if (cmd.draw_rd) draw_row_reg <= line_row;
        if (cmd.exec && nib == 4'h2 && 32'(depth_reg) < STACK_DEPTH)
            stack_mem[SW'(depth_reg)] <= pc2;
        if (cmd.row_cap)
            row_reg <= (32'(row_idx_reg) < SCREEN_ROWS) ? fs_cur : 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) v_reg[i] <= 8'd0;
            index_reg    <= 16'd0;
            pc_reg       <= c8exec_pkg::PC_RESET;
            depth_reg    <= '0;
            delay_reg    <= 8'd0;
            sound_reg    <= 8'd0;
            status_reg   <= c8exec_pkg::ST_OK;
            fs_valid_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            if (in_fire) begin
                status_reg <= c8exec_pkg::ST_OK;
                cnt_reg    <= '0;
            end
            if (cmd.exec) begin
                pc_reg <= pc2;
                unique case (nib)
                    4'h0: begin
                        if (x == 4'h0 && kk == c8exec_pkg::KK_CLS) begin
                            fs_valid_reg <= '0;
                        end else if (x == 4'h0 && kk == c8exec_pkg::KK_RET) begin
                            if (depth_reg == '0) status_reg <= c8exec_pkg::ST_STACK;
                            else begin
                                depth_reg <= depth_reg - DW'(1);
                                pc_reg <= stack_mem[SW'(depth_reg - DW'(1))];
                            end
                        end else status_reg <= c8exec_pkg::ST_UNKNOWN;
                    end
                    4'h1: pc_reg <= nnn;
                    4'h2: begin
                        if (32'(depth_reg) >= STACK_DEPTH) status_reg <= c8exec_pkg::ST_STACK;
                        else begin
                            depth_reg <= depth_reg + DW'(1);
                            pc_reg <= nnn;
                        end
                    end
                    4'h3: if (vx == kk) pc_reg <= pc4;
                    4'h4: if (vx != kk) pc_reg <= pc4;
                    4'h5: if (vx == vy) pc_reg <= pc4;
                    4'h6: v_reg[x] <= kk;
                    4'h7: v_reg[x] <= vx + kk;
                    4'h8: begin
                        // flag is written first, subtract and shift results computed from updated regs;
                        // the add and the logic ops take their operands as they came in
                        logic [7:0] fl, ax, ay, res;
                        logic [8:0] sum;
                        logic       known, wr_fl;
                        fl = 8'd0;
                        ax = vx;
                        ay = vy;
                        res = vx;
                        known = 1'b1;
                        wr_fl = 1'b1;
                        sum = 9'(vx) + 9'(vy);
                        case (n)
                            4'h4: fl = {7'd0, sum[8]};
                            4'h5: fl = {7'd0, vx > vy};
                            4'h6: fl = {7'd0, vx[0]};
                            4'h7: fl = {7'd0, vy > vx};
                            4'hE: fl = {7'd0, vx[7]};
                            default: fl = 8'd0;
                        endcase
                        if (x == 4'hF) ax = fl;
                        if (y == 4'hF) ay = fl;
                        case (n)
                            4'h0: begin res = vy; wr_fl = 1'b0; end
                            4'h1: begin res = vx | vy; wr_fl = 1'b0; end
                            4'h2: begin res = vx & vy; wr_fl = 1'b0; end
                            4'h3: begin res = vx ^ vy; wr_fl = 1'b0; end
                            4'h4: res = sum[7:0];
                            4'h5: res = ax - ay;
                            4'h6: res = ax >> 1;
                            4'h7: res = ay - ax;
                            4'hE: res = ax << 1;
                            default: begin
                                known = 1'b0;
                                wr_fl = 1'b0;
                            end
                        endcase
                        if (!known) status_reg <= c8exec_pkg::ST_UNKNOWN;
                        else v_reg[x] <= res;
                        // result lands last, so VF as destination keeps the result
                        if (wr_fl && x != 4'hF) v_reg[15] <= fl;
                    end
                    4'h9: if (vx != vy) pc_reg <= pc4;
                    4'hA: index_reg <= {4'd0, nnn};
                    4'hB: pc_reg <= nnn + {4'd0, v_reg[0]};
                    4'hC: v_reg[x] <= rnd_reg & kk;
                    4'hD: v_reg[15] <= 8'd0;
                    4'hE: begin
                        if (kk == c8exec_pkg::KK_SKP || kk == c8exec_pkg::KK_SKNP)
                            status_reg <= c8exec_pkg::ST_UNIMPL;
                        else status_reg <= c8exec_pkg::ST_UNKNOWN;
                    end
                    4'hF: begin
                        unique case (kk)
                            c8exec_pkg::KK_GDT:  v_reg[x] <= delay_reg;
                            c8exec_pkg::KK_SDT:  delay_reg <= vx;
                            c8exec_pkg::KK_SST:  sound_reg <= vx;
                            c8exec_pkg::KK_ADDI: index_reg <= index_reg + {8'd0, vx};
                            c8exec_pkg::KK_STOR, c8exec_pkg::KK_LDR: ;
                            c8exec_pkg::KK_KEY, c8exec_pkg::KK_FONT, c8exec_pkg::KK_BCD:
                                status_reg <= c8exec_pkg::ST_UNIMPL;
                            default: status_reg <= c8exec_pkg::ST_UNKNOWN;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (cmd.clr_step) begin
                cnt_reg <= cnt_reg + NW'(1);
            end
            if (cmd.draw_wr) begin
                fs_valid_reg[draw_row_reg] <= 1'b1;
                if ((fs_cur & spr_mask) != 64'd0) v_reg[15] <= 8'd1;
                cnt_reg <= cnt_reg + NW'(1);
            end
            if (cmd.store_step) cnt_reg <= cnt_reg + NW'(1);
            if (cmd.load_wr) begin
                v_reg[cnt_reg[3:0]] <= mem_q;
                cnt_reg <= cnt_reg + NW'(1);
            end
        end
    end

    assign pc_out     = pc_reg;
    assign index_out  = index_reg;
    assign flag_out   = v_reg[15];
    assign status_out = status_reg;
    assign row_out    = row_reg;
    assign delay_out  = delay_reg;
    assign sound_out  = sound_reg;
endmodule

@@ sv/chip8_instruction_executor_core.sv @@
// CHIP-8 executor core: one request in, one result out. CLS steps through every
// screen row (SCREEN_ROWS), a sprite draw does a memory read then a frame
// read-modify-write per sprite line, Fx55 stores and Fx65 reads then writes
// one register per step. The display is cleared at reset by per-row valid bits.
`include "chip8_instruction_executor_core_defines.svh"
module chip8_instruction_executor_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[1:0], instruction[17:2], random_byte[25:18], load_address[37:26],
    // load_data[45:38], row_index[50:46], zero fill to 56
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // program_counter[11:0], index_value[27:12], flag_value[35:28], status[37:36],
    // display_row[101:38], delay_value[109:102], sound_value[117:110], zero fill to 120
    output logic [119:0] m_tdata
);
    c8exec_pkg::c8_cmd_t  cmd;
    c8exec_pkg::c8_stat_t stat;
    logic busy, done, in_fire, out_free;
    logic m_valid_reg;
    logic [119:0] m_data_reg;
    logic [11:0] pc;
    logic [15:0] idx;
    logic [7:0] fl, dl, sn;
    logic [1:0] st;
    logic [63:0] row;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    c8exec_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_opcode(s_tdata[1:0]),
        .out_free(out_free), .stat(stat), .cmd(cmd), .busy(busy), .done(done)
    );

    c8exec_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_instruction(s_tdata[17:2]), .in_random_byte(s_tdata[25:18]),
        .in_load_address(s_tdata[37:26]), .in_load_data(s_tdata[45:38]),
        .in_row_index(s_tdata[50:46]), .cmd(cmd), .stat(stat),
        .pc_out(pc), .index_out(idx), .flag_out(fl), .status_out(st),
        .row_out(row), .delay_out(dl), .sound_out(sn)
    );

    logic is_row_reg;
    always_ff @(posedge aclk) begin
        if (in_fire) is_row_reg <= (s_tdata[1:0] == c8exec_pkg::OP_ROW);
        if (done)
            m_data_reg <= {2'd0, sn, dl, (is_row_reg ? row : 64'd0), st, fl, idx, pc};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (done) m_valid_reg <= 1'b1;
        else if (m_tready) m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `C8_ASSERT_NEXT(a_done_valid, aclk, aresetn, done, m_tvalid)
    `C8_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, busy |-> !in_fire)
    `C8_ASSERT_IMPL(a_done_free, aclk, aresetn, done |-> out_free)
endmodule
